### rtl/sha1_pkg.sv
// Package: types, constants and round helpers for the SHA-1 byte stream hasher.
`default_nettype none
package sha1_pkg;
    localparam int QueueDepth = 4;
    localparam int QueueAw = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } out_item_t;

    // classified command between front and back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } cmd_t;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    function automatic logic [31:0] round_const(input logic [6:0] r);
        logic [31:0] k;
        begin
            if (r < 7'd20) k = 32'h5A827999;
            else if (r < 7'd40) k = 32'h6ED9EBA1;
            else if (r < 7'd60) k = 32'h8F1BBCDC;
            else k = 32'hCA62C1D6;
            return k;
        end
    endfunction

    function automatic logic [31:0] round_fn(input logic [6:0] r, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            if (r < 7'd20) f = (b & c) | (~b & d);
            else if (r >= 7'd40 && r < 7'd60) f = (b & c) | (b & d) | (c & d);
            else f = b ^ c ^ d;
            return f;
        end
    endfunction
endpackage
`default_nettype wire

### rtl/sha1_queue.sv
// Module: short command queue between the front and the back.
`default_nettype none
module sha1_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire sha1_pkg::cmd_t wr_data,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output sha1_pkg::cmd_t     rd_data
);
    sha1_pkg::cmd_t mem_reg [sha1_pkg::QueueDepth];
    logic [sha1_pkg::QueueAw-1:0] wptr_reg, rptr_reg;
    logic [sha1_pkg::QueueAw:0]   cnt_reg;
    logic wr_en, rd_en;

    assign wr_ready = (cnt_reg != sha1_pkg::QueueAw'(0) + (sha1_pkg::QueueAw+1)'(sha1_pkg::QueueDepth));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rptr_reg];
    assign wr_en = wr_valid && wr_ready;
    assign rd_en = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr_en) wptr_reg <= wptr_reg + 1'b1;
            if (rd_en) rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (sha1_pkg::QueueAw+1)'(wr_en) - (sha1_pkg::QueueAw+1)'(rd_en);
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (sha1_pkg::QueueAw+1)'(sha1_pkg::QueueDepth)) else $error("queue overflow");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wptr_reg == rptr_reg)) else $error("pointer mismatch");
    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        !wr_ready |=> cnt_reg == $past(cnt_reg) - (sha1_pkg::QueueAw+1)'($past(rd_en)))
        else $error("write when full");
endmodule
`default_nettype wire

### rtl/sha1_core.sv
// Module: back end; packs bytes, pads, runs 80 rounds and emits the digest.
`default_nettype none
module sha1_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire sha1_pkg::cmd_t cmd,
    output logic                out_valid,
    input  wire logic           out_ready,
    output sha1_pkg::out_item_t out_data
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w_reg [16];
    logic [5:0]  pos_reg;
    logic [63:0] len_reg;
    logic [6:0]  rnd_reg;
    logic        fin_reg;   // message end pending
    logic        two_reg;   // second padding block needed
    logic        lenw_reg;  // block holding the bit length has been loaded
    logic [2:0]  oidx_reg;

    logic [31:0] t_val, w_new, w_cur;
    logic [3:0]  bidx;
    logic [4:0]  bsh;
    logic [5:0]  pos_inc;

    assign w_cur = w_reg[0];
    assign w_new = {w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]};
    assign t_val = {a_reg[26:0], a_reg[31:27]} + sha1_pkg::round_fn(rnd_reg, b_reg, c_reg, d_reg)
                   + e_reg + sha1_pkg::round_const(rnd_reg) + w_cur;
    assign bidx = pos_reg[5:2];
    assign bsh  = 5'(5'd24 - {pos_reg[1:0], 3'b000});
    assign pos_inc = pos_reg + 6'd1;

    assign cmd_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data.digest_word = h_reg[oidx_reg];
    assign out_data.word_number = oidx_reg;
    assign out_data.last_word = (oidx_reg == 3'd4);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (cmd_valid)
                begin
                    if (cmd.byte_present && pos_inc == 6'd0) state_next = S_ROUND;
                    else if (cmd.end_of_message) state_next = S_PAD;
                end
            S_PAD:   state_next = S_ROUND;
            S_ROUND: if (rnd_reg == 7'd79) state_next = S_ADD;
            S_ADD:   state_next = !fin_reg ? S_IDLE : (lenw_reg ? S_OUT : S_PAD);
            S_OUT:   if (out_ready && oidx_reg == 3'd4) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (cmd_valid && cmd.byte_present)
                begin
                    w_reg[bidx] <= (w_reg[bidx] & ~(32'hFF << bsh))
                                   | (32'(cmd.data_byte) << bsh);
                end
            S_PAD:
                if (!two_reg || pos_reg != 6'd0)
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        if (4'(i) > bidx) w_reg[i] <= '0;
                        else if (4'(i) == bidx)
                            w_reg[i] <= (w_reg[i] & ~(32'hFFFFFFFF >> (5'd24 - bsh)))
                                        | (32'h80 << bsh);
                    end
                    if (pos_reg < 6'd56)
                    begin
                        w_reg[14] <= len_reg[63:32];
                        w_reg[15] <= len_reg[31:0];
                    end
                end
                else
                begin
                    for (int i = 0; i < 14; i++) w_reg[i] <= '0;
                    w_reg[14] <= len_reg[63:32];
                    w_reg[15] <= len_reg[31:0];
                end
            S_ROUND:
            begin
                for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                w_reg[15] <= {w_new[30:0], w_new[31]};
            end
            default: ;
        endcase
        if (state_reg == S_ROUND)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        else
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            h_reg[0] <= sha1_pkg::H0;
            h_reg[1] <= sha1_pkg::H1;
            h_reg[2] <= sha1_pkg::H2;
            h_reg[3] <= sha1_pkg::H3;
            h_reg[4] <= sha1_pkg::H4;
            pos_reg <= '0;
            len_reg <= '0;
            rnd_reg <= '0;
            fin_reg <= 1'b0;
            two_reg <= 1'b0;
            lenw_reg <= 1'b0;
            oidx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                    if (cmd_valid)
                    begin
                        fin_reg <= cmd.end_of_message;
                        lenw_reg <= 1'b0;
                        rnd_reg <= '0;
                        if (cmd.byte_present)
                        begin
                            pos_reg <= pos_inc;
                            len_reg <= len_reg + 64'd8;
                        end
                        two_reg <= cmd.byte_present ? (pos_inc >= 6'd56)
                                                    : (pos_reg >= 6'd56);
                    end
                S_PAD:
                begin
                    // first pad pass with 56+ bytes: keep two_reg, mark done via pos
                    if (two_reg && pos_reg != 6'd0) pos_reg <= '0;
                    else
                    begin
                        two_reg <= 1'b0;
                        lenw_reg <= 1'b1;
                    end
                    rnd_reg <= '0;
                end
                S_ROUND: rnd_reg <= rnd_reg + 7'd1;
                S_ADD:
                begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    rnd_reg <= '0;
                    oidx_reg <= '0;
                end
                S_OUT:
                    if (out_ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd4)
                        begin
                            h_reg[0] <= sha1_pkg::H0;
                            h_reg[1] <= sha1_pkg::H1;
                            h_reg[2] <= sha1_pkg::H2;
                            h_reg[3] <= sha1_pkg::H3;
                            h_reg[4] <= sha1_pkg::H4;
                            pos_reg <= '0;
                            len_reg <= '0;
                            fin_reg <= 1'b0;
                            lenw_reg <= 1'b0;
                        end
                    end
                default: ;
            endcase
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && rnd_reg == 7'd79) |=> state_reg == S_ADD)
        else $error("round count");
    a_out_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> oidx_reg <= 3'd4) else $error("word index");
endmodule
`default_nettype wire

### rtl/sha1_byte_stream_hasher.sv
// Top level: SHA-1 hasher fed one byte per transaction.
// Each transaction is queued (depth 4) and taken by the hash engine. A byte
// is taken while the engine is idle; the 64th byte of a block starts the 80
// rounds and the chaining update, during which the engine takes no bytes.
// End of message pads one or two blocks, each run through the rounds, then the five
// digest words leave one per transaction, most significant first.
`default_nettype none
module sha1_byte_stream_hasher (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sha1_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output sha1_pkg::out_item_t      out_data
);
    sha1_pkg::cmd_t q_in, q_out;
    logic q_valid, q_ready;

    assign q_in.data_byte      = in_data.data_byte;
    assign q_in.byte_present   = in_data.byte_present;
    assign q_in.end_of_message = in_data.end_of_message;

    sha1_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(in_valid), .wr_ready(in_ready), .wr_data(q_in),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_out)
    );

    sha1_core u_core (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_out),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );
endmodule
`default_nettype wire

### test/tb_top.sv
// Testbench for the SHA-1 byte stream hasher: random message streams checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    sha1_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    sha1_pkg::out_item_t out_data;

    sha1_byte_stream_hasher dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #10 clk = ~clk;

    sha1_pkg::in_item_t pending_bytes[$];
    sha1_pkg::out_item_t expected_words[$];
    int mismatches = 0;
    bit no_idle = 1'b0;

    logic [31:0] chain[5];
    logic [31:0] blk[16];
    logic [5:0] pos;
    logic [63:0] bit_len;

    function automatic logic [31:0] rol(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic hash_block();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endtask

    task automatic restart_message();
        chain[0] = sha1_pkg::H0; chain[1] = sha1_pkg::H1; chain[2] = sha1_pkg::H2;
        chain[3] = sha1_pkg::H3; chain[4] = sha1_pkg::H4;
        pos = '0;
        bit_len = '0;
    endtask

    task automatic store_byte(logic [5:0] p, logic [7:0] v);
        blk[p[5:2]][(3 - p[1:0]) * 8 +: 8] = v;
    endtask

    task automatic predict_digest(sha1_pkg::in_item_t it);
        sha1_pkg::out_item_t o;
        if (it.byte_present)
        begin
            store_byte(pos, it.data_byte);
            bit_len += 64'd8;
            pos = pos + 6'd1;
            if (pos == 0) hash_block();
        end
        if (!it.end_of_message) return;
        store_byte(pos, 8'h80);
        for (int p = pos + 1; p < 64; p++) store_byte(p[5:0], 8'h00);
        if (pos >= 6'd56)
        begin
            hash_block();
            for (int i = 0; i < 16; i++) blk[i] = '0;
        end
        blk[14] = bit_len[63:32];
        blk[15] = bit_len[31:0];
        hash_block();
        for (int i = 0; i < 5; i++)
        begin
            o.digest_word = chain[i];
            o.word_number = 3'(i);
            o.last_word = (i == 4);
            expected_words.push_back(o);
        end
        restart_message();
    endtask

    function automatic sha1_pkg::in_item_t mk(logic [7:0] v, logic p, logic e);
        sha1_pkg::in_item_t it;
        it.data_byte = v; it.byte_present = p; it.end_of_message = e;
        return it;
    endfunction

    task automatic add_message(int len, bit end_with_byte);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                pending_bytes.push_back(mk(8'($urandom), 1'b0, 1'b0));
            pending_bytes.push_back(mk(8'($urandom), 1'b1,
                                      end_with_byte && i == len - 1));
        end
        if (!end_with_byte || len == 0)
            pending_bytes.push_back(mk(8'($urandom), 1'b0, 1'b1));
    endtask

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            predict_digest(in_data);
            void'(pending_bytes.pop_front());
        end
        if ((in_valid && !in_ready) || (pending_bytes.size() > 0
                && rst_n && (no_idle || $urandom_range(0, 99) >= 7)))
        begin
            in_valid <= 1'b1;
            if (!(in_valid && !in_ready)) in_data <= pending_bytes[0];
        end
        else
        begin
            in_valid <= 1'b0;
        end
        out_ready <= rst_n && (no_idle || $urandom_range(0, 99) >= 7);
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: %h %0d %b", out_data.digest_word,
                             out_data.word_number, out_data.last_word);
            end
            else
            begin
                sha1_pkg::out_item_t exp_w;
                exp_w = expected_words.pop_front();
                if (out_data !== exp_w)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %0d %b got %h %0d %b",
                                 exp_w.digest_word, exp_w.word_number, exp_w.last_word,
                                 out_data.digest_word, out_data.word_number,
                                 out_data.last_word);
                end
            end
        end
    end

    initial
    begin
        restart_message();
        for (int i = 0; i < 16; i++) blk[i] = '0;
        // directed: empty, one byte with end, extremes, full tails, no-op items
        add_message(0, 1'b0);
        pending_bytes.push_back(mk(8'h00, 1'b0, 1'b0));
        pending_bytes.push_back(mk(8'hFF, 1'b1, 1'b1));
        pending_bytes.push_back(mk(8'h00, 1'b1, 1'b0));
        pending_bytes.push_back(mk(8'hFF, 1'b1, 1'b0));
        pending_bytes.push_back(mk(8'hAA, 1'b0, 1'b1));
        add_message(3, 1'b1);
        add_message(56, 1'b1);
        add_message(64, 1'b1);
        add_message(60, 1'b0);
        for (int m = 0; m < 6; m++)
            add_message($urandom_range(0, 6), 1'($urandom));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_bytes.size() == 0);
        wait (expected_words.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("PASS sha1_byte_stream_hasher");
        else
            $display("FAIL sha1_byte_stream_hasher");
        $finish;
    end

    initial
    begin
        #10000;
        no_idle = 1'b1;
        #20000;
        no_idle = 1'b0;
    end

    initial
    begin
        #20000000;
        $display("FAIL sha1_byte_stream_hasher");
        $finish;
    end
endmodule

### files.f
rtl/sha1_pkg.sv
rtl/sha1_queue.sv
rtl/sha1_core.sv
rtl/sha1_byte_stream_hasher.sv
test/tb_top.sv
